// ===== rtl/ray_triangle_closest_hit_assert.svh =====
// Assertion macros for the ray/triangle nearest-hit block.
// Used by ray_triangle_closest_hit.sv; expects clk and rst_n in scope.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_ASSERT_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RTCH_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rtch: assertion failed");
`define RTCH_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rtch: assertion failed");
`else
`define RTCH_ASSERT(lbl, cond)
`define RTCH_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/rtch_pkg.sv =====
// Types, codes and the product schedule of the ray/triangle nearest-hit block.
// No dependencies.
package rtch_pkg;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_CHECK, S_DIVT, S_DIST, S_NPREP, S_NSHIFT,
        S_SQINIT, S_SQRT, S_NDSET, S_NDIV, S_FIN
    } state_t;

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_DET_THR  = 3'd6;

    localparam logic [39:0] DET_THR_RESET = 40'd1678;

    // multiplier operand sources
    localparam logic [4:0] SRC_D0  = 5'd0;
    localparam logic [4:0] SRC_D1  = 5'd1;
    localparam logic [4:0] SRC_D2  = 5'd2;
    localparam logic [4:0] SRC_E10 = 5'd3;
    localparam logic [4:0] SRC_E11 = 5'd4;
    localparam logic [4:0] SRC_E12 = 5'd5;
    localparam logic [4:0] SRC_E20 = 5'd6;
    localparam logic [4:0] SRC_E21 = 5'd7;
    localparam logic [4:0] SRC_E22 = 5'd8;
    localparam logic [4:0] SRC_TV0 = 5'd9;
    localparam logic [4:0] SRC_TV1 = 5'd10;
    localparam logic [4:0] SRC_TV2 = 5'd11;
    localparam logic [4:0] SRC_PV0 = 5'd12;
    localparam logic [4:0] SRC_PV1 = 5'd13;
    localparam logic [4:0] SRC_PV2 = 5'd14;
    localparam logic [4:0] SRC_QV0 = 5'd15;
    localparam logic [4:0] SRC_QV1 = 5'd16;
    localparam logic [4:0] SRC_QV2 = 5'd17;
    localparam logic [4:0] SRC_AN0 = 5'd18;
    localparam logic [4:0] SRC_AN1 = 5'd19;
    localparam logic [4:0] SRC_AN2 = 5'd20;
    localparam int         SRC_COUNT = 21;

    // accumulator destinations
    localparam logic [3:0] DST_PV0 = 4'd0;
    localparam logic [3:0] DST_PV1 = 4'd1;
    localparam logic [3:0] DST_PV2 = 4'd2;
    localparam logic [3:0] DST_DET = 4'd3;
    localparam logic [3:0] DST_U   = 4'd4;
    localparam logic [3:0] DST_QV0 = 4'd5;
    localparam logic [3:0] DST_QV1 = 4'd6;
    localparam logic [3:0] DST_QV2 = 4'd7;
    localparam logic [3:0] DST_V   = 4'd8;
    localparam logic [3:0] DST_TN  = 4'd9;
    localparam logic [3:0] DST_NC0 = 4'd10;
    localparam logic [3:0] DST_NC1 = 4'd11;
    localparam logic [3:0] DST_NC2 = 4'd12;
    localparam logic [3:0] DST_SS  = 4'd13;

    // schedule landmarks
    localparam logic [5:0] STEP_TN_END = 6'd23;
    localparam logic [5:0] STEP_NC     = 6'd24;
    localparam logic [5:0] STEP_NC_END = 6'd29;
    localparam logic [5:0] STEP_SS     = 6'd30;
    localparam logic [5:0] STEP_SS_END = 6'd32;

    typedef struct packed {
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic       neg;
        logic       last;
        logic [3:0] dst;
    } step_t;

    function automatic step_t step_info(input logic [5:0] idx);
        step_t s;
        s = '{src_a: SRC_D0, src_b: SRC_D0, neg: 1'b0, last: 1'b0, dst: DST_PV0};
        case (idx)
            // pv = dir x e2
            6'd0:  s = '{SRC_D1,  SRC_E22, 1'b0, 1'b0, DST_PV0};
            6'd1:  s = '{SRC_D2,  SRC_E21, 1'b1, 1'b1, DST_PV0};
            6'd2:  s = '{SRC_D2,  SRC_E20, 1'b0, 1'b0, DST_PV1};
            6'd3:  s = '{SRC_D0,  SRC_E22, 1'b1, 1'b1, DST_PV1};
            6'd4:  s = '{SRC_D0,  SRC_E21, 1'b0, 1'b0, DST_PV2};
            6'd5:  s = '{SRC_D1,  SRC_E20, 1'b1, 1'b1, DST_PV2};
            // det = e1 . pv
            6'd6:  s = '{SRC_E10, SRC_PV0, 1'b0, 1'b0, DST_DET};
            6'd7:  s = '{SRC_E11, SRC_PV1, 1'b0, 1'b0, DST_DET};
            6'd8:  s = '{SRC_E12, SRC_PV2, 1'b0, 1'b1, DST_DET};
            // u = tv . pv
            6'd9:  s = '{SRC_TV0, SRC_PV0, 1'b0, 1'b0, DST_U};
            6'd10: s = '{SRC_TV1, SRC_PV1, 1'b0, 1'b0, DST_U};
            6'd11: s = '{SRC_TV2, SRC_PV2, 1'b0, 1'b1, DST_U};
            // qv = tv x e1
            6'd12: s = '{SRC_TV1, SRC_E12, 1'b0, 1'b0, DST_QV0};
            6'd13: s = '{SRC_TV2, SRC_E11, 1'b1, 1'b1, DST_QV0};
            6'd14: s = '{SRC_TV2, SRC_E10, 1'b0, 1'b0, DST_QV1};
            6'd15: s = '{SRC_TV0, SRC_E12, 1'b1, 1'b1, DST_QV1};
            6'd16: s = '{SRC_TV0, SRC_E11, 1'b0, 1'b0, DST_QV2};
            6'd17: s = '{SRC_TV1, SRC_E10, 1'b1, 1'b1, DST_QV2};
            // v = dir . qv
            6'd18: s = '{SRC_D0,  SRC_QV0, 1'b0, 1'b0, DST_V};
            6'd19: s = '{SRC_D1,  SRC_QV1, 1'b0, 1'b0, DST_V};
            6'd20: s = '{SRC_D2,  SRC_QV2, 1'b0, 1'b1, DST_V};
            // tn = e2 . qv
            6'd21: s = '{SRC_E20, SRC_QV0, 1'b0, 1'b0, DST_TN};
            6'd22: s = '{SRC_E21, SRC_QV1, 1'b0, 1'b0, DST_TN};
            6'd23: s = '{SRC_E22, SRC_QV2, 1'b0, 1'b1, DST_TN};
            // nc = e1 x e2
            6'd24: s = '{SRC_E11, SRC_E22, 1'b0, 1'b0, DST_NC0};
            6'd25: s = '{SRC_E12, SRC_E21, 1'b1, 1'b1, DST_NC0};
            6'd26: s = '{SRC_E12, SRC_E20, 1'b0, 1'b0, DST_NC1};
            6'd27: s = '{SRC_E10, SRC_E22, 1'b1, 1'b1, DST_NC1};
            6'd28: s = '{SRC_E10, SRC_E21, 1'b0, 1'b0, DST_NC2};
            6'd29: s = '{SRC_E11, SRC_E20, 1'b1, 1'b1, DST_NC2};
            // sum of squares of the scaled normal
            6'd30: s = '{SRC_AN0, SRC_AN0, 1'b0, 1'b0, DST_SS};
            6'd31: s = '{SRC_AN1, SRC_AN1, 1'b0, 1'b0, DST_SS};
            6'd32: s = '{SRC_AN2, SRC_AN2, 1'b0, 1'b1, DST_SS};
            default: s = '{SRC_D0, SRC_D0, 1'b0, 1'b0, DST_PV0};
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/ray_triangle_closest_hit.sv =====
// Nearest ray/triangle hit over a stream of triangles, one shared multiplier.
// Depends on rtch_pkg and ray_triangle_closest_hit_assert.svh.
`include "ray_triangle_closest_hit_assert.svh"
// A triangle request that misses or is no nearer than the held hit runs from
// acceptance to the next acceptance through 24 products in the single 36x36
// multiplier (each a multiply step, then an accumulate step), the hit check and
// a closing state. A hit adds the 32 steps of the bit-serial divider for the
// distance and the compare with the held best (a saturated distance skips the
// divider). A new nearest hit adds the normal: 6 more products, one normalizing
// shift per cycle, 3 squares, a 32-step square root and three divisions.
// The block takes no request while a triangle is in flight; a finished result
// waits in the output register and does not block the next triangle until the
// next last triangle has to deliver its own result.
module ray_triangle_closest_hit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    input  logic signed [15:0] c_x,
    input  logic signed [15:0] c_y,
    input  logic signed [15:0] c_z,
    input  logic               last_triangle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               any_hit,
    output logic [31:0]        closest_distance,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z
);
    import rtch_pkg::*;

    state_t state_reg, state_next;

    logic signed [15:0] origin_reg [3];
    logic signed [15:0] dir_reg [3];
    logic [39:0]        thr_reg;

    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [16:0] tv_reg [3];
    logic               last_reg;

    logic signed [35:0] pv_reg [3];
    logic signed [35:0] qv_reg [3];
    logic signed [35:0] nc_reg [3];
    logic signed [53:0] det_reg, u_reg, v_reg, tn_reg;
    logic [61:0]        ss_reg;

    logic [5:0]         step_reg;
    logic signed [63:0] prod_reg, acc_reg;

    logic [54:0] rem_reg;
    logic [53:0] den_reg;
    logic [31:0] shr_reg;
    logic [31:0] quo_reg;
    logic [5:0]  cnt_reg;

    logic [34:0] an_reg [3];
    logic [34:0] m_reg;
    logic [2:0]  neg_reg;
    logic [61:0] sq_x_reg;
    logic [62:0] sq_r_reg, sq_bit_reg;
    logic [1:0]  nidx_reg;

    logic [31:0]        best_dist_reg;
    logic signed [15:0] best_norm_reg [3];
    logic               hit_seen_reg;

    logic               out_valid_reg, out_hit_reg;
    logic [31:0]        out_dist_reg;
    logic signed [15:0] out_norm_reg [3];

    // ---------------- configuration port
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_comb
    begin
        case (cfg_idx)
            REG_ORIGIN_X: prdata = {48'd0, origin_reg[0]};
            REG_ORIGIN_Y: prdata = {48'd0, origin_reg[1]};
            REG_ORIGIN_Z: prdata = {48'd0, origin_reg[2]};
            REG_DIR_X:    prdata = {48'd0, dir_reg[0]};
            REG_DIR_Y:    prdata = {48'd0, dir_reg[1]};
            REG_DIR_Z:    prdata = {48'd0, dir_reg[2]};
            REG_DET_THR:  prdata = {24'd0, thr_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= '0;
            thr_reg       <= DET_THR_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ORIGIN_X: origin_reg[0] <= pwdata[15:0];
                REG_ORIGIN_Y: origin_reg[1] <= pwdata[15:0];
                REG_ORIGIN_Z: origin_reg[2] <= pwdata[15:0];
                REG_DIR_X:    dir_reg[0]    <= pwdata[15:0];
                REG_DIR_Y:    dir_reg[1]    <= pwdata[15:0];
                REG_DIR_Z:    dir_reg[2]    <= pwdata[15:0];
                REG_DET_THR:  thr_reg       <= pwdata[39:0];
                default:      ;
            endcase
        end
    end

    // ---------------- shared multiplier and accumulator
    step_t              stp;
    logic signed [35:0] src_vec [SRC_COUNT];
    logic signed [35:0] op_a, op_b;
    logic signed [71:0] mul_full;
    logic signed [63:0] addend, acc_sum;

    assign stp = step_info(step_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            src_vec[SRC_D0 + i]  = 36'(dir_reg[i]);
            src_vec[SRC_E10 + i] = 36'(e1_reg[i]);
            src_vec[SRC_E20 + i] = 36'(e2_reg[i]);
            src_vec[SRC_TV0 + i] = 36'(tv_reg[i]);
            src_vec[SRC_PV0 + i] = pv_reg[i];
            src_vec[SRC_QV0 + i] = qv_reg[i];
            src_vec[SRC_AN0 + i] = $signed({1'b0, an_reg[i]});
        end
    end

    assign op_a     = (stp.src_a <= SRC_AN2) ? src_vec[stp.src_a] : '0;
    assign op_b     = (stp.src_b <= SRC_AN2) ? src_vec[stp.src_b] : '0;
    assign mul_full = op_a * op_b;
    assign addend   = stp.neg ? -prod_reg : prod_reg;
    assign acc_sum  = acc_reg + addend;

    // ---------------- hit test
    logic        det_ok, u_ok, v_ok, tn_ok, hit_now, t_sat;
    logic [54:0] uv_sum;

    assign det_ok  = !det_reg[53] && (det_reg[52:0] >= 53'(thr_reg));
    assign u_ok    = !u_reg[53] && (u_reg <= det_reg);
    assign uv_sum  = {1'b0, u_reg} + {1'b0, v_reg};
    assign v_ok    = !v_reg[53] && (uv_sum <= {1'b0, det_reg});
    assign tn_ok   = !tn_reg[53];
    assign hit_now = det_ok && u_ok && v_ok && tn_ok;
    // quotient would not fit 24 integer bits (also covers a zero determinant)
    assign t_sat   = 77'(tn_reg[52:0]) >= {det_reg[52:0], 24'd0};

    // ---------------- shared restoring divider step
    logic [54:0] rem_shift;
    logic        rem_ge;

    assign rem_shift = {rem_reg[53:0], shr_reg[31]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};

    // ---------------- normal helpers
    logic [35:0] nc_abs [3];
    logic [34:0] nc_max;
    logic [62:0] sq_try;
    logic        sq_ge;
    logic [44:0] nd_num;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nc_abs[i] = nc_reg[i][35] ? 36'(-nc_reg[i]) : 36'(nc_reg[i]);
        end
        nc_max = nc_abs[0][34:0];
        if (nc_abs[1][34:0] > nc_max)
        begin
            nc_max = nc_abs[1][34:0];
        end
        if (nc_abs[2][34:0] > nc_max)
        begin
            nc_max = nc_abs[2][34:0];
        end
    end

    assign sq_try = sq_r_reg + sq_bit_reg;
    assign sq_ge  = {1'b0, sq_x_reg} >= sq_try;
    assign nd_num = {an_reg[nidx_reg][29:0], 14'd0} + 45'(sq_r_reg[31:1]);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // ---------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            S_MUL:
                state_next = S_ACC;
            S_ACC:
                if (step_reg == STEP_TN_END)
                begin
                    state_next = S_CHECK;
                end
                else if (step_reg == STEP_NC_END)
                begin
                    state_next = S_NPREP;
                end
                else if (step_reg == STEP_SS_END)
                begin
                    state_next = S_SQINIT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            S_CHECK:
                if (!hit_now)
                begin
                    state_next = S_FIN;
                end
                else if (t_sat)
                begin
                    state_next = S_DIST;
                end
                else
                begin
                    state_next = S_DIVT;
                end
            S_DIVT:
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_DIST;
                end
            S_DIST:
                state_next = (quo_reg < best_dist_reg) ? S_MUL : S_FIN;
            S_NPREP:
                state_next = (nc_max == '0) ? S_FIN : S_NSHIFT;
            S_NSHIFT:
                if (m_reg[34:30] == '0 && m_reg[29])
                begin
                    state_next = S_MUL;
                end
            S_SQINIT:
                state_next = S_SQRT;
            S_SQRT:
                if (sq_bit_reg == 63'd1)
                begin
                    state_next = S_NDSET;
                end
            S_NDSET:
                state_next = S_NDIV;
            S_NDIV:
                if (cnt_reg == 6'd1)
                begin
                    state_next = (nidx_reg == 2'd2) ? S_FIN : S_NDSET;
                end
            S_FIN:
                if (!last_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // ---------------- control state: step counter, held best, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= '0;
            acc_reg          <= '0;
            best_dist_reg    <= '1;
            best_norm_reg[0] <= '0;
            best_norm_reg[1] <= '0;
            best_norm_reg[2] <= '0;
            hit_seen_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // a new result loaded in the same cycle keeps valid high
            if (out_valid_reg && out_ready && !(state_reg == S_FIN && last_reg))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        step_reg <= '0;
                        acc_reg  <= '0;
                    end
                S_ACC:
                begin
                    step_reg <= step_reg + 6'd1;
                    acc_reg  <= stp.last ? 64'sd0 : acc_sum;
                end
                S_DIST:
                begin
                    hit_seen_reg <= 1'b1;
                    if (quo_reg < best_dist_reg)
                    begin
                        best_dist_reg <= quo_reg;
                        step_reg      <= STEP_NC;
                    end
                end
                S_NPREP:
                    if (nc_max == '0)
                    begin
                        best_norm_reg[0] <= '0;
                        best_norm_reg[1] <= '0;
                        best_norm_reg[2] <= '0;
                    end
                S_NSHIFT:
                    step_reg <= STEP_SS;
                S_NDIV:
                    // last quotient bit joins in this cycle
                    if (cnt_reg == 6'd1)
                    begin
                        best_norm_reg[nidx_reg] <= neg_reg[nidx_reg]
                            ? -$signed({quo_reg[14:0], rem_ge})
                            : $signed({quo_reg[14:0], rem_ge});
                    end
                S_FIN:
                    if (last_reg && out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        best_dist_reg    <= '1;
                        best_norm_reg[0] <= '0;
                        best_norm_reg[1] <= '0;
                        best_norm_reg[2] <= '0;
                        hit_seen_reg     <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    // ---------------- datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    e1_reg[0] <= 17'(b_x) - 17'(a_x);
                    e1_reg[1] <= 17'(b_y) - 17'(a_y);
                    e1_reg[2] <= 17'(b_z) - 17'(a_z);
                    e2_reg[0] <= 17'(c_x) - 17'(a_x);
                    e2_reg[1] <= 17'(c_y) - 17'(a_y);
                    e2_reg[2] <= 17'(c_z) - 17'(a_z);
                    tv_reg[0] <= 17'(origin_reg[0]) - 17'(a_x);
                    tv_reg[1] <= 17'(origin_reg[1]) - 17'(a_y);
                    tv_reg[2] <= 17'(origin_reg[2]) - 17'(a_z);
                    last_reg  <= last_triangle;
                end
            S_MUL:
                prod_reg <= mul_full[63:0];
            S_ACC:
                if (stp.last)
                begin
                    case (stp.dst)
                        DST_PV0: pv_reg[0] <= acc_sum[35:0];
                        DST_PV1: pv_reg[1] <= acc_sum[35:0];
                        DST_PV2: pv_reg[2] <= acc_sum[35:0];
                        DST_DET: det_reg   <= acc_sum[53:0];
                        DST_U:   u_reg     <= acc_sum[53:0];
                        DST_QV0: qv_reg[0] <= acc_sum[35:0];
                        DST_QV1: qv_reg[1] <= acc_sum[35:0];
                        DST_QV2: qv_reg[2] <= acc_sum[35:0];
                        DST_V:   v_reg     <= acc_sum[53:0];
                        DST_TN:  tn_reg    <= acc_sum[53:0];
                        DST_NC0: nc_reg[0] <= acc_sum[35:0];
                        DST_NC1: nc_reg[1] <= acc_sum[35:0];
                        DST_NC2: nc_reg[2] <= acc_sum[35:0];
                        DST_SS:  ss_reg    <= acc_sum[61:0];
                        default: ;
                    endcase
                end
            S_CHECK:
                if (t_sat)
                begin
                    quo_reg <= '1;
                end
                else
                begin
                    rem_reg <= 55'(tn_reg[52:24]);
                    shr_reg <= {tn_reg[23:0], 8'd0};
                    den_reg <= det_reg;
                    quo_reg <= '0;
                    cnt_reg <= 6'd32;
                end
            S_DIVT, S_NDIV:
            begin
                rem_reg <= rem_ge ? rem_shift - {1'b0, den_reg} : rem_shift;
                quo_reg <= {quo_reg[30:0], rem_ge};
                shr_reg <= {shr_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
                if (state_reg == S_NDIV && cnt_reg == 6'd1)
                begin
                    nidx_reg <= nidx_reg + 2'd1;
                end
            end
            S_NPREP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    an_reg[i]  <= nc_abs[i][34:0];
                    neg_reg[i] <= nc_reg[i][35];
                end
                m_reg <= nc_max;
            end
            S_NSHIFT:
                if (m_reg[34:30] != '0)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        an_reg[i] <= an_reg[i] >> 1;
                    end
                end
                else if (!m_reg[29])
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        an_reg[i] <= an_reg[i] << 1;
                    end
                end
            S_SQINIT:
            begin
                sq_x_reg   <= ss_reg;
                sq_r_reg   <= '0;
                sq_bit_reg <= 63'd1 << 62;
                nidx_reg   <= '0;
            end
            S_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_x_reg <= 62'({1'b0, sq_x_reg} - sq_try);
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            S_NDSET:
            begin
                rem_reg <= 55'(nd_num[44:16]);
                shr_reg <= {nd_num[15:0], 16'd0};
                den_reg <= 54'(sq_r_reg[31:0]);
                quo_reg <= '0;
                cnt_reg <= 6'd16;
            end
            S_FIN:
                if (last_reg && out_free)
                begin
                    out_hit_reg     <= hit_seen_reg;
                    out_dist_reg    <= best_dist_reg;
                    out_norm_reg[0] <= best_norm_reg[0];
                    out_norm_reg[1] <= best_norm_reg[1];
                    out_norm_reg[2] <= best_norm_reg[2];
                end
            default: ;
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign any_hit          = out_hit_reg;
    assign closest_distance = out_dist_reg;
    assign normal_x         = out_norm_reg[0];
    assign normal_y         = out_norm_reg[1];
    assign normal_z         = out_norm_reg[2];

    // ---------------- assertions
    `RTCH_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    `RTCH_ASSERT(a_miss_clean, !(out_valid && !any_hit) || (closest_distance == 32'hFFFF_FFFF && normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0))
    `RTCH_ASSERT(a_normal_range, !out_valid || (normal_x >= -16'sd16384 && normal_x <= 16'sd16384 && normal_y >= -16'sd16384 && normal_y <= 16'sd16384 && normal_z >= -16'sd16384 && normal_z <= 16'sd16384))

endmodule
